FILE: hdl/tree_path_distance_lca_core_macros.svh
`ifndef TREE_PATH_DISTANCE_LCA_CORE_MACROS_SVH
`define TREE_PATH_DISTANCE_LCA_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define TPD_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tpd_lca check failed");

// next-cycle implication, quiet during reset
`define TPD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tpd_lca check failed");

// next-cycle implication, also checked through reset
`define TPD_ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("tpd_lca check failed");

`endif

FILE: hdl/tpd_lca_pkg.sv
package tpd_lca_pkg;

  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 26;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

FILE: hdl/tpd_lca_ram.sv
module tpd_lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hdl/tpd_lca_out_reg.sv
module tpd_lca_out_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [tpd_lca_pkg::DIST_W-1:0] push_data,
  output logic                           slot_free,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tpd_lca_pkg::DIST_W-1:0] out_path_distance
);

  logic                           valid_r;
  logic [tpd_lca_pkg::DIST_W-1:0] data_r;

  assign slot_free         = !valid_r || out_ready;
  assign out_valid         = valid_r;
  assign out_path_distance = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule

FILE: hdl/tree_path_distance_lca_core.sv
// weighted tree distance engine, binary-lifting lowest common ancestor
// input channel (in_valid / in_ready): in_op selects a load request (child
// in_node_a under parent in_node_b, edge in_weight) or a query request
// (distance between in_node_a and in_node_b). only queries give a result,
// on out_valid / out_ready as out_path_distance, from an output register.
// one request at a time: in_ready is high only while the sequencer idles.
// every node row (depth, root distance, LEVELS ancestors) sits in one RAM
// with two registered read ports, walked by the sequencer one level a step.
// a load reads one ancestor row per level; a rejected load returns to
// idle straight from decode.
// a query runs a lifting pass over every level, with a RAM read for each
// set bit of the depth difference, and, unless one node sits above the
// other, a meeting pass over every level, with a read where the ancestors
// differ, and then one parent read.
// a new request is taken while a result waits in the output register; a
// finished query holds until that register frees, so out_ready low stalls
// the block only at the end of the next query.
// after reset a clearing pass writes NODES zero rows, one per cycle, with
// in_ready low throughout.
module tree_path_distance_lca_core #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [tpd_lca_pkg::NODE_W-1:0]   in_node_a,
  input  logic [tpd_lca_pkg::NODE_W-1:0]   in_node_b,
  input  logic [tpd_lca_pkg::WEIGHT_W-1:0] in_weight,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tpd_lca_pkg::DIST_W-1:0]   out_path_distance
);

  localparam int NW = tpd_lca_pkg::NODE_W;
  localparam int DW = tpd_lca_pkg::DIST_W;
  localparam int AW = $clog2(NODES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LW-1:0]     J_LAST    = LW'(LEVELS - 1);
  localparam logic [LEVELS-1:0] DEPTH_MAX = {LEVELS{1'b1}};

  typedef struct packed {
    logic [LEVELS-1:0][NW-1:0] anc;
    logic [DW-1:0]             root_dist;
    logic [LEVELS-1:0]         depth;
  } row_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_L_PAR, S_L_CAP, S_L_WRITE,
    S_Q_ROWS, S_Q_LIFT, S_Q_LIFT_CAP, S_Q_MEET, S_Q_DOWN, S_Q_DOWN_CAP,
    S_Q_PAR, S_Q_PCAP, S_Q_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic                             op_r, op_nxt;
  logic [NW-1:0]                    a_r, a_nxt, b_r, b_nxt;
  logic [tpd_lca_pkg::WEIGHT_W-1:0] w_r, w_nxt;
  logic [NW-1:0]                    u_r, u_nxt, v_r, v_nxt;
  row_t                             urow_r, urow_nxt, vrow_r, vrow_nxt;
  logic [LEVELS-1:0]                k_r, k_nxt;
  logic [LW-1:0]                    j_r, j_nxt;
  logic [DW:0]                      sum_r, sum_nxt;
  logic [DW-1:0]                    dp_r, dp_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, raddr_a, raddr_b;
  row_t          ram_wdata, rd_a, rd_b;

  logic          push, slot_free;
  logic          load_bad;
  logic [NW-1:0] qa, qb, lx, lval, pu, pv;
  logic [LW-1:0] jm1;
  logic [DW:0]   lsum;
  logic [DW+1:0] qdiff;
  logic [DW-1:0] qres;

  tpd_lca_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NODES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  tpd_lca_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .push_data         (qres),
    .slot_free         (slot_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_path_distance (out_path_distance)
  );

  assign in_ready = (state_r == S_IDLE);

  assign load_bad = (32'(a_r) >= NODES) || (32'(b_r) >= NODES) ||
                    (a_r == NW'(0)) || (a_r == NW'(1)) || (a_r == b_r);
  assign qa = (32'(a_r) < NODES) ? a_r : '0;
  assign qb = (32'(b_r) < NODES) ? b_r : '0;

  // ancestor step of a load, with bypass when the walk comes back to the child
  assign jm1  = LW'(j_r - 1'b1);
  assign lx   = urow_r.anc[jm1];
  assign lval = (lx == a_r) ? lx : rd_a.anc[jm1];
  assign lsum = {1'b0, rd_a.root_dist} + (DW + 1)'(w_r);

  assign pu = urow_r.anc[j_r];
  assign pv = vrow_r.anc[j_r];

  assign qdiff = (DW + 2)'(sum_r) - (DW + 2)'({dp_r, 1'b0});
  assign qres  = qdiff[DW+1] ? '0 : (qdiff[DW] ? tpd_lca_pkg::DIST_MAX : qdiff[DW-1:0]);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    urow_nxt  = urow_r;
    vrow_nxt  = vrow_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    sum_nxt   = sum_r;
    dp_nxt    = dp_r;
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '0;
    raddr_a   = '0;
    raddr_b   = '0;
    push      = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = AW'(clr_r + 1'b1);
        if (clr_r == AW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          a_nxt     = in_node_a;
          b_nxt     = in_node_b;
          w_nxt     = in_weight;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (op_r == tpd_lca_pkg::OP_LOAD) begin
          raddr_a   = AW'(b_r);
          state_nxt = load_bad ? S_IDLE : S_L_PAR;
        end else begin
          raddr_a   = AW'(qa);
          raddr_b   = AW'(qb);
          u_nxt     = qa;
          v_nxt     = qb;
          state_nxt = S_Q_ROWS;
        end
      end
      S_L_PAR: begin
        urow_nxt.depth  = (rd_a.depth == DEPTH_MAX) ? DEPTH_MAX : LEVELS'(rd_a.depth + 1'b1);
        urow_nxt.root_dist = lsum[DW] ? tpd_lca_pkg::DIST_MAX : lsum[DW-1:0];
        urow_nxt.anc    = '0;
        urow_nxt.anc[0] = b_r;
        raddr_a         = AW'(b_r);
        j_nxt           = LW'(1);
        state_nxt       = (LEVELS > 1) ? S_L_CAP : S_L_WRITE;
      end
      S_L_CAP: begin
        urow_nxt.anc[j_r] = lval;
        raddr_a           = AW'(lval);
        j_nxt             = LW'(j_r + 1'b1);
        if (j_r == J_LAST) begin
          state_nxt = S_L_WRITE;
        end
      end
      S_L_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(a_r);
        ram_wdata = urow_r;
        state_nxt = S_IDLE;
      end
      S_Q_ROWS: begin
        sum_nxt = {1'b0, rd_a.root_dist} + {1'b0, rd_b.root_dist};
        j_nxt   = '0;
        if (rd_a.depth < rd_b.depth) begin
          u_nxt    = v_r;
          v_nxt    = u_r;
          urow_nxt = rd_b;
          vrow_nxt = rd_a;
          k_nxt    = LEVELS'(rd_b.depth - rd_a.depth);
        end else begin
          urow_nxt = rd_a;
          vrow_nxt = rd_b;
          k_nxt    = LEVELS'(rd_a.depth - rd_b.depth);
        end
        state_nxt = S_Q_LIFT;
      end
      S_Q_LIFT: begin
        if (k_r[j_r]) begin
          raddr_a   = AW'(pu);
          u_nxt     = pu;
          state_nxt = S_Q_LIFT_CAP;
        end else if (j_r == J_LAST) begin
          state_nxt = S_Q_MEET;
        end else begin
          j_nxt = LW'(j_r + 1'b1);
        end
      end
      S_Q_LIFT_CAP: begin
        urow_nxt = rd_a;
        if (j_r == J_LAST) begin
          state_nxt = S_Q_MEET;
        end else begin
          j_nxt     = LW'(j_r + 1'b1);
          state_nxt = S_Q_LIFT;
        end
      end
      S_Q_MEET: begin
        j_nxt = J_LAST;
        if (u_r == v_r) begin
          dp_nxt    = urow_r.root_dist;
          state_nxt = S_Q_DONE;
        end else begin
          state_nxt = S_Q_DOWN;
        end
      end
      S_Q_DOWN: begin
        if (pu != pv) begin
          raddr_a   = AW'(pu);
          raddr_b   = AW'(pv);
          u_nxt     = pu;
          v_nxt     = pv;
          state_nxt = S_Q_DOWN_CAP;
        end else if (j_r == '0) begin
          state_nxt = S_Q_PAR;
        end else begin
          j_nxt = LW'(j_r - 1'b1);
        end
      end
      S_Q_DOWN_CAP: begin
        urow_nxt = rd_a;
        vrow_nxt = rd_b;
        if (j_r == '0) begin
          state_nxt = S_Q_PAR;
        end else begin
          j_nxt     = LW'(j_r - 1'b1);
          state_nxt = S_Q_DOWN;
        end
      end
      S_Q_PAR: begin
        raddr_a   = AW'(urow_r.anc[0]);
        state_nxt = S_Q_PCAP;
      end
      S_Q_PCAP: begin
        dp_nxt    = rd_a.root_dist;
        state_nxt = S_Q_DONE;
      end
      S_Q_DONE: begin
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    w_r    <= w_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    urow_r <= urow_nxt;
    vrow_r <= vrow_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    sum_r  <= sum_nxt;
    dp_r   <= dp_nxt;
  end

endmodule

FILE: hdl/tpd_lca_checker.sv
`include "tree_path_distance_lca_core_macros.svh"

module tpd_lca_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tpd_lca_pkg::DIST_W-1:0] out_path_distance
);

  // a waiting result holds its value
  `TPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_path_distance))

  // clearing pass keeps both sides quiet after reset
  `TPD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid && !in_ready)

  // in_ready drops after every accepted request, so the block is busy
  `TPD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // a result appears exactly as the sequencer returns to idle
  `TPD_ASSERT_IMPL(a_result_at_idle, clk, rst_n, $rose(out_valid), in_ready && !$past(in_ready))

endmodule

bind tree_path_distance_lca_core tpd_lca_checker u_tpd_lca_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_path_distance (out_path_distance)
);

FILE: tb/sv/tree_path_distance_lca_checker.sv
`timescale 1ns / 100ps

module tree_path_distance_lca_checker #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             in_op,
  input  logic [tpd_lca_pkg::NODE_W-1:0]   in_node_a,
  input  logic [tpd_lca_pkg::NODE_W-1:0]   in_node_b,
  input  logic [tpd_lca_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [tpd_lca_pkg::DIST_W-1:0]   out_path_distance,
  output int                               mismatches,
  output int                               pending,
  output int                               results_seen
);

  localparam int NW = tpd_lca_pkg::NODE_W;
  localparam int DW = tpd_lca_pkg::DIST_W;
  localparam int WW = tpd_lca_pkg::WEIGHT_W;
  localparam int DEPTH_W = LEVELS;
  localparam logic [DEPTH_W-1:0] DEPTH_CAP = '1;

  logic [DEPTH_W-1:0] depth_of    [NODES];
  logic [DW-1:0]      dist_of     [NODES];
  logic [NW-1:0]      ancestor_of [NODES][LEVELS];

  logic [DW-1:0] expected_distances [$];
  int mismatch_total;
  int checked_total;

  initial begin
    mismatches = 0;
    pending = 0;
    results_seen = 0;
    mismatch_total = 0;
    checked_total = 0;
  end

  function automatic logic [NW-1:0] node_or_sentinel(input logic [NW-1:0] n);
    return (n < NODES) ? n : '0;
  endfunction

  function automatic logic [NW-1:0] hop(input logic [NW-1:0] n, input int j);
    return node_or_sentinel(ancestor_of[n][j]);
  endfunction

  task automatic attach_node(input logic [NW-1:0] child, input logic [NW-1:0] parent,
                             input logic [WW-1:0] w);
    logic [DW:0] sum;
    if (child >= NODES || parent >= NODES) return;
    if (child == 0 || child == 1 || child == parent) return;
    depth_of[child] = (depth_of[parent] == DEPTH_CAP) ? DEPTH_CAP : depth_of[parent] + 1'b1;
    sum = {1'b0, dist_of[parent]} + w;
    dist_of[child] = (sum > tpd_lca_pkg::DIST_MAX) ? tpd_lca_pkg::DIST_MAX : sum[DW-1:0];
    ancestor_of[child][0] = parent;
    for (int j = 1; j < LEVELS; j++)
      ancestor_of[child][j] = hop(hop(child, j - 1), j - 1);
  endtask

  function automatic logic [DW-1:0] predict_distance(input logic [NW-1:0] a,
                                                     input logic [NW-1:0] b);
    logic [NW-1:0] ua, vb, u, v, t, meet;
    logic [DEPTH_W-1:0] k;
    longint diff;
    ua = node_or_sentinel(a);
    vb = node_or_sentinel(b);
    u = ua;
    v = vb;
    if (depth_of[u] < depth_of[v]) begin
      t = u;
      u = v;
      v = t;
    end
    k = depth_of[u] - depth_of[v];
    for (int j = 0; j < LEVELS; j++)
      if (k[j]) u = hop(u, j);
    if (u == v) begin
      meet = u;
    end else begin
      for (int j = LEVELS - 1; j >= 0; j--) begin
        if (hop(u, j) != hop(v, j)) begin
          t = hop(u, j);
          v = hop(v, j);
          u = t;
        end
      end
      meet = hop(u, 0);
    end
    diff = longint'(dist_of[ua]) + longint'(dist_of[vb]) - 2 * longint'(dist_of[meet]);
    if (diff < 0) return '0;
    if (diff > longint'(tpd_lca_pkg::DIST_MAX)) return tpd_lca_pkg::DIST_MAX;
    return diff[DW-1:0];
  endfunction

  always @(posedge clk) begin
    logic [DW-1:0] want;
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        depth_of[n] = '0;
        dist_of[n] = '0;
        for (int j = 0; j < LEVELS; j++) ancestor_of[n][j] = '0;
      end
      expected_distances.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        checked_total++;
        if (expected_distances.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("unexpected result: path_distance %0d with no query waiting",
                     out_path_distance);
        end else begin
          want = expected_distances.pop_front();
          if (out_path_distance !== want) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("mismatch on result %0d: expected path_distance %0d, got %0d",
                       checked_total, want, out_path_distance);
          end
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        if (in_op == tpd_lca_pkg::OP_QUERY)
          expected_distances = {expected_distances, predict_distance(in_node_a, in_node_b)};
        else
          attach_node(in_node_a, in_node_b, in_weight);
      end
    end
    mismatches <= mismatch_total;
    pending <= expected_distances.size();
    results_seen <= checked_total;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int NW = tpd_lca_pkg::NODE_W;
  localparam int WW = tpd_lca_pkg::WEIGHT_W;
  localparam int DW = tpd_lca_pkg::DIST_W;
  localparam int NODES = 1024;
  localparam int LEVELS = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 410;
  localparam int CLIMB_LOADS = 600;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_op = tpd_lca_pkg::OP_LOAD;
  logic [NW-1:0] in_node_a = '0;
  logic [NW-1:0] in_node_b = '0;
  logic [WW-1:0] in_weight = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [DW-1:0] out_path_distance;

  int mismatches;
  int pending;
  int results_seen;
  int cycle_count = 0;
  int loads_sent = 0;
  int queries_sent = 0;
  bit source_idling = 1'b1;

  logic [NW-1:0] tree_nodes [$];
  bit is_loaded [NODES];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  tree_path_distance_lca_core #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_path_distance(out_path_distance)
  );

  tree_path_distance_lca_checker #(
    .NODES (NODES),
    .LEVELS(LEVELS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_path_distance(out_path_distance),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_seen     (results_seen)
  );

  initial begin : sink_pacing
    int hold, span, r;
    bit sink_calm;
    hold = 0;
    span = 0;
    sink_calm = 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        sink_calm = ($urandom_range(3) == 0);
        span = $urandom_range(400, 100);
      end
      span--;
      if (hold > 0) begin
        hold--;
      end else if (sink_calm) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          out_ready <= 1'b1;
          hold = $urandom_range(5);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          hold = $urandom_range(3, 1);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(30, 10);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!source_idling) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [NW-1:0] pick_child();
    logic [NW-1:0] c;
    c = NW'($urandom_range(NODES - 1, 2));
    // now and then overwrite a node already in the tree
    if ($urandom_range(19) == 0) return c;
    for (int t = 0; t < 16; t++)
      if (is_loaded[c]) c = NW'($urandom_range(NODES - 1, 2));
    return c;
  endfunction

  function automatic logic [NW-1:0] pick_tree_node();
    return tree_nodes[$urandom_range(tree_nodes.size() - 1)];
  endfunction

  task automatic send_request(input logic op, input logic [NW-1:0] a,
                              input logic [NW-1:0] b, input logic [WW-1:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_node_a <= a;
    in_node_b <= b;
    in_weight <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (op == tpd_lca_pkg::OP_QUERY) begin
      queries_sent++;
    end else begin
      loads_sent++;
      if (a >= 2 && a != b && !is_loaded[a]) begin
        is_loaded[a] = 1'b1;
        tree_nodes = {tree_nodes, a};
      end
    end
  endtask

  task automatic send_load(input logic [NW-1:0] child, input logic [NW-1:0] parent,
                           input logic [WW-1:0] w);
    send_request(tpd_lca_pkg::OP_LOAD, child, parent, w);
  endtask

  task automatic send_query(input logic [NW-1:0] a, input logic [NW-1:0] b);
    send_request(tpd_lca_pkg::OP_QUERY, a, b, WW'($urandom));
  endtask

  initial begin : stimulus
    logic [NW-1:0] x, y, child, parent, last_child;
    int r, style;
    is_loaded[1] = 1'b1;
    tree_nodes = {tree_nodes, NW'(1)};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty tables, ignored loads, caps at the edges of the fields
    send_query(10'd0, 10'd0);
    send_query(10'd1, 10'd1);
    send_query(10'd5, 10'd9);
    send_load(10'd0, 10'd1, 16'hFFFF);
    send_load(10'd1, 10'd2, 16'hFFFF);
    send_load(10'd7, 10'd7, 16'h0101);
    send_load(10'd2, 10'd1, 16'hFFFF);
    send_load(10'd3, 10'd2, 16'h0000);
    send_load(10'd1023, 10'd3, 16'h8001);
    send_load(10'd4, 10'd1, 16'h1234);
    send_load(10'd600, 10'd900, 16'h00FF);
    send_query(10'd1023, 10'd4);
    send_query(10'd4, 10'd1023);
    send_query(10'd1023, 10'd1023);
    send_query(10'd1023, 10'd0);
    send_request(tpd_lca_pkg::OP_QUERY, 10'd1023, 10'd1, 16'hFFFF);
    send_query(10'd600, 10'd1023);
    // reparent a node that already has a child below it
    send_load(10'd3, 10'd4, 16'h0005);
    send_query(10'd1023, 10'd3);
    send_query(10'd1023, 10'd2);
    send_load(10'd512, 10'd1023, 16'hFFFF);
    send_query(10'd512, 10'd4);
    send_query(10'd512, 10'd1023);

    // two nodes hung under each other in turn for a deep chain
    x = pick_child();
    send_load(x, 10'd1, 16'($urandom));
    y = pick_child();
    while (y == x) y = pick_child();
    for (int n = 0; n < CLIMB_LOADS; n++) begin
      if (n % 300 == 0) source_idling = ($urandom_range(2) != 0);
      if (n % 2 == 0) send_load(y, x, 16'($urandom_range(65535, 62000)));
      else send_load(x, y, 16'($urandom_range(65535, 62000)));
      if (n % 37 == 0) send_query((n % 4 == 0) ? x : y, pick_tree_node());
    end
    send_query(x, y);
    send_query(y, 10'd1);

    last_child = 10'd1;
    style = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) style = $urandom_range(2);
      if (n % 150 == 0) source_idling = ($urandom_range(3) != 0);
      r = $urandom_range(99);
      if (r < ((style == 2) ? 15 : 45)) begin
        child = pick_child();
        if (style == 0 && $urandom_range(99) < 85) parent = last_child;
        else parent = pick_tree_node();
        while (child == parent) child = pick_child();
        send_load(child, parent, 16'($urandom));
        last_child = child;
      end else if (r < 88) begin
        if ($urandom_range(9) == 0) send_query(NW'($urandom), pick_tree_node());
        else send_query(pick_tree_node(), pick_tree_node());
      end else begin
        send_request(1'($urandom), NW'($urandom), NW'($urandom), 16'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * LEVELS + 20) @(posedge clk);

    $display("sent %0d loads and %0d queries, %0d distances compared",
             loads_sent, queries_sent, results_seen);
    $display("tree of %0d nodes, one pair stacked %0d levels deep",
             tree_nodes.size(), CLIMB_LOADS);
    if (mismatches == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/tpd_lca_pkg.sv
hdl/tpd_lca_ram.sv
hdl/tpd_lca_out_reg.sv
hdl/tree_path_distance_lca_core.sv
hdl/tpd_lca_checker.sv
tb/sv/tree_path_distance_lca_checker.sv
tb/sv/testbench.sv
